[rtl/gfs_pkg.sv]
// Package for the frame sync and CRC-32 checker: queue entry type, operation codes,
// register indexes, sync constants and the byte-wide reflected CRC update.
// Depends on nothing; every other file imports it.
package gfs_pkg;

    localparam logic [31:0] SYNC_WORD       = 32'hAA44121C;
    localparam logic [7:0]  SYNC_BYTES [4]  = '{8'hAA, 8'h44, 8'h12, 8'h1C};
    localparam int          MIN_FRAME_BYTES = 8;
    localparam int          FRAME_LEN_W     = 11;
    localparam int          CFG_INDEX_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLYNOMIAL = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH   = 8'd1;

    localparam logic [31:0]            RESET_POLYNOMIAL   = 32'hEDB88320;
    localparam logic [FRAME_LEN_W-1:0] RESET_FRAME_LENGTH = 11'd112;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [1:0] OP_SYNC  = 2'd0;
    localparam logic [1:0] OP_CRC   = 2'd1;
    localparam logic [1:0] OP_TRAIL = 2'd2;
    localparam logic [1:0] OP_LAST  = 2'd3;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data_byte;
    } t_op;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] t;
        t = {24'h0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            if (t[0]) begin
                t = (t >> 1) ^ poly;
            end else begin
                t = t >> 1;
            end
        end
        return {8'h00, crc[31:8]} ^ t;
    endfunction

endpackage

[rtl/gfs_if.sv]
// Handshake channels of the frame sync and CRC-32 checker: byte input, result output
// and configuration write. Depends on gfs_pkg.
interface gfs_byte_if import gfs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface gfs_res_if import gfs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;

    modport source (output valid, output crc_ok, output computed_crc, output received_crc,
                    input ready);
    modport sink (input valid, input crc_ok, input computed_crc, input received_crc,
                  output ready);
endinterface

interface gfs_cfg_if import gfs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/gfs_front.sv]
// Front end: sync word hunt, frame byte counting and classification of each byte
// into a queue operation. Depends on gfs_pkg.
module gfs_front import gfs_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic [FRAME_LEN_W-1:0] i_frame_length,
    output logic                   o_push,
    output t_op                    o_op
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EW    = (LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W;
    localparam logic [EW-1:0] MAX_LEN = EW'(MAX_FRAME_BYTES);
    localparam logic [EW-1:0] MIN_LEN = EW'(MIN_FRAME_BYTES);

    logic [31:0]      r_window, n_window;
    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count, n_count;

    logic [EW-1:0] w_len_raw, w_len, w_pos;
    logic [31:0]   w_window;
    logic          w_is_crc, w_is_last;

    assign w_len_raw = EW'(i_frame_length);
    assign w_len     = (w_len_raw < MIN_LEN) ? MIN_LEN :
                       (w_len_raw > MAX_LEN) ? MAX_LEN : w_len_raw;
    assign w_pos     = EW'(r_count);
    assign w_is_crc  = w_pos < (w_len - EW'(4));
    assign w_is_last = w_pos >= (w_len - EW'(1));
    assign w_window  = {r_window[23:0], i_data_byte};

    always_comb begin
        n_window       = r_window;
        n_in_frame     = r_in_frame;
        n_count        = r_count;
        o_push         = 1'b0;
        o_op.code      = OP_CRC;
        o_op.data_byte = i_data_byte;
        if (i_accept) begin
            if (!r_in_frame) begin
                n_window = w_window;
                if (w_window == SYNC_WORD) begin
                    o_push     = 1'b1;
                    o_op.code  = OP_SYNC;
                    n_in_frame = 1'b1;
                    n_count    = CNT_W'(4);
                end
            end else begin
                o_push = 1'b1;
                if (w_is_last) begin
                    o_op.code  = OP_LAST;
                    n_in_frame = 1'b0;
                    n_window   = 32'h0;
                    n_count    = '0;
                end else begin
                    o_op.code = w_is_crc ? OP_CRC : OP_TRAIL;
                    n_count   = CNT_W'(r_count + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 32'h0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_window   <= n_window;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> r_count >= CNT_W'(4))
        else $error("Frame byte count below the sync length inside a frame.");

    a_count_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_count == '0)
        else $error("Frame byte count not cleared while hunting.");

    a_hunt_push_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_frame && o_push) |-> o_op.code == OP_SYNC)
        else $error("An item other than the sync mark was queued while hunting.");

endmodule

[rtl/gfs_queue.sv]
// Short queue of classified operations between the front end and the CRC back end.
// Depends on gfs_pkg.
module gfs_queue import gfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_op  o_op
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/gfs_back.sv]
// Back end: running CRC and trailer assembly, result register, and the sync-word
// CRC that is recomputed after reset and after each polynomial write. Depends on gfs_pkg.
module gfs_back import gfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  t_op         i_op,
    output logic        o_op_ready,
    input  logic [31:0] i_poly,
    input  logic        i_poly_wr,
    output logic        o_pre_busy,
    gfs_res_if.source   o_res
);

    logic [31:0] r_crc, r_trail, r_pre_crc;
    logic        r_pre_busy;
    logic [1:0]  r_pre_idx;
    logic        r_out_valid, r_out_ok;
    logic [31:0] r_out_computed, r_out_received;

    logic        w_pop;
    logic [31:0] w_trail;

    assign o_op_ready = (i_op.code != OP_LAST) || !r_out_valid || o_res.ready;
    assign w_pop      = i_op_valid && o_op_ready;
    assign w_trail    = {i_op.data_byte, r_trail[31:8]};
    assign o_pre_busy = r_pre_busy;

    assign o_res.valid        = r_out_valid;
    assign o_res.crc_ok       = r_out_ok;
    assign o_res.computed_crc = r_out_computed;
    assign o_res.received_crc = r_out_received;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 32'h0;
            r_trail     <= 32'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                case (i_op.code)
                    OP_SYNC: begin
                        r_crc   <= r_pre_crc;
                        r_trail <= 32'h0;
                    end
                    OP_CRC: begin
                        r_crc <= crc_byte(r_crc, i_op.data_byte, i_poly);
                    end
                    OP_TRAIL: begin
                        r_trail <= w_trail;
                    end
                    OP_LAST: begin
                        r_out_valid <= 1'b1;
                        r_crc       <= 32'h0;
                        r_trail     <= 32'h0;
                    end
                    default: begin
                        r_crc <= r_crc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_op.code == OP_LAST) begin
            r_out_ok       <= r_crc == w_trail;
            r_out_computed <= r_crc;
            r_out_received <= w_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_busy <= 1'b1;
            r_pre_idx  <= 2'd0;
            r_pre_crc  <= 32'h0;
        end else if (i_poly_wr) begin
            r_pre_busy <= 1'b1;
            r_pre_idx  <= 2'd0;
            r_pre_crc  <= 32'h0;
        end else if (r_pre_busy) begin
            r_pre_crc <= crc_byte(r_pre_crc, SYNC_BYTES[r_pre_idx], i_poly);
            r_pre_idx <= r_pre_idx + 1'b1;
            if (r_pre_idx == 2'd3) begin
                r_pre_busy <= 1'b0;
            end
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_op.code == OP_LAST) |=> r_out_valid)
        else $error("Frame end did not load the result register.");

    a_result_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_res.crc_ok == (o_res.computed_crc == o_res.received_crc)))
        else $error("Match flag disagrees with the two CRC values.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !(w_pop && i_op.code == OP_LAST))
        else $error("A waiting result was overwritten.");

endmodule

[rtl/gfs_pkg_dummy_guard.sv]
// Configuration register file of the frame sync and CRC-32 checker: polynomial and
// frame length, with a strobe on each polynomial write. Depends on gfs_pkg and gfs_if.
module gfs_cfg_regs import gfs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gfs_cfg_if.sink                i_cfg,
    output logic [31:0]            o_poly,
    output logic [FRAME_LEN_W-1:0] o_frame_length,
    output logic                   o_poly_wr
);

    logic [31:0]            r_poly;
    logic [FRAME_LEN_W-1:0] r_frame_length;
    logic                   w_write;

    assign i_cfg.ready    = 1'b1;
    assign w_write        = i_cfg.valid && i_cfg.ready;
    assign o_poly_wr      = w_write && (i_cfg.index == CFG_CRC_POLYNOMIAL);
    assign o_poly         = r_poly;
    assign o_frame_length = r_frame_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly         <= RESET_POLYNOMIAL;
            r_frame_length <= RESET_FRAME_LENGTH;
        end else if (w_write) begin
            case (i_cfg.index)
                CFG_CRC_POLYNOMIAL: begin
                    r_poly <= i_cfg.data;
                end
                CFG_FRAME_LENGTH: begin
                    r_frame_length <= i_cfg.data[FRAME_LEN_W-1:0];
                end
                default: begin
                    r_poly <= r_poly;
                end
            endcase
        end
    end

endmodule

[rtl/gnss_frame_sync_crc32_check.sv]
// Channel   Role    Payload
// i_byte    sink    data_byte[7:0]
// o_res     source  crc_ok, computed_crc[31:0], received_crc[31:0]
// i_cfg     sink    index[7:0], data[31:0]; 0 polynomial, 1 frame length
//
// One byte is taken per cycle while the queue has room; the back end updates the CRC
// one byte per cycle unless a waiting result stalls it. Reset is synchronous; after
// reset and each polynomial write, input is held while the sync-word CRC is recomputed.
// A frame result waits in an output register while following bytes are still taken,
// until the four-entry operation queue fills.
module gnss_frame_sync_crc32_check import gfs_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gfs_byte_if.sink  i_byte,
    gfs_res_if.source o_res,
    gfs_cfg_if.sink   i_cfg
);

    logic [31:0]            w_poly;
    logic [FRAME_LEN_W-1:0] w_frame_length;
    logic                   w_poly_wr, w_pre_busy;
    logic                   w_accept, w_push, w_q_valid, w_q_full, w_op_ready;
    t_op                    w_front_op, w_q_op;

    assign i_byte.ready = !w_q_full && !w_pre_busy;
    assign w_accept     = i_byte.valid && i_byte.ready;

    gfs_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (i_cfg),
        .o_poly         (w_poly),
        .o_frame_length (w_frame_length),
        .o_poly_wr      (w_poly_wr)
    );

    gfs_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_byte.data_byte),
        .i_frame_length (w_frame_length),
        .o_push         (w_push),
        .o_op           (w_front_op)
    );

    gfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_op_ready),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_op    (w_q_op)
    );

    gfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_q_valid),
        .i_op       (w_q_op),
        .o_op_ready (w_op_ready),
        .i_poly     (w_poly),
        .i_poly_wr  (w_poly_wr),
        .o_pre_busy (w_pre_busy),
        .o_res      (o_res)
    );

endmodule
